// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
// The property samples on clk and is ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/kstab_pkg.sv -----
package kstab_pkg;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_SWAP   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_FIND   = 3'd5;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_MISSING  = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_BAD_KEY  = 3'd4;

  localparam int          TOTAL_BITS = 21;
  localparam logic [20:0] TOTAL_MAX  = 21'h1FFFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] key;
    logic [15:0] amount;
    logic [4:0]  slot_a;
    logic [4:0]  slot_b;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  found_slot;
    logic [20:0] key_total;
    logic        enough;
    logic [15:0] slot_key;
    logic [15:0] slot_amount;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_UPDATE,
    S_SW_B,
    S_SW_WA,
    S_SW_WB,
    S_RD
  } state_t;

endpackage

// ----- design/keyed_slot_count_table.sv -----
// Add, remove, query and find walk the slots in S_SCAN and S_LAST and answer from S_UPDATE;
// swap goes through S_SW_B, S_SW_WA and S_SW_WB, read slot through S_RD, and rejected or
// trivial items answer from idle. A new item is taken only once busy drops; scans are paced
// by the single slot memory read port that the scan walks one slot per cycle.
// Reset (rst_n low, synchronous) empties every slot and drops any item in progress.
// Results are a one-cycle strobe; the receiver cannot stall the block.
`include "assert_macros.svh"

module keyed_slot_count_table #(
  parameter int SLOTS        = 32,
  parameter int FRONT_WINDOW = 8,
  parameter int COUNT_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kstab_pkg::in_t    in_data,
  output logic              out_valid,
  output kstab_pkg::out_t   out_data
);

  // Slot index width and the width of the shared adder/subtractor. The adder must hold a
  // count plus a 16-bit amount and the running total plus a count without wrapping.
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = ((COUNT_BITS > kstab_pkg::TOTAL_BITS) ? COUNT_BITS
                                                            : kstab_pkg::TOTAL_BITS) + 1;

  // Slot storage. The key and count arrays share one address and are read through a
  // registered port. A valid bit per slot makes a never-written slot read as empty, so
  // reset clears the table at once without a sweep.
  logic [15:0]           key_mem [SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0]      valid_r;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [15:0]           rd_key_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic                  rd_vld_r;

  logic                  we;
  logic [IW-1:0]         wr_addr;
  logic [15:0]           wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;

  // Sequencer and working registers.
  kstab_pkg::state_t     state_r, state_nxt;
  kstab_pkg::in_t        req_r, req_nxt;
  logic [IW-1:0]         addr_r, addr_nxt;
  logic [20:0]           acc_r, acc_nxt;
  logic                  hit_r, hit_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic                  emp_r, emp_nxt;
  logic [IW-1:0]         emp_idx_r, emp_idx_nxt;
  logic [15:0]           hold_key_r, hold_key_nxt;
  logic [COUNT_BITS-1:0] hold_cnt_r, hold_cnt_nxt;
  kstab_pkg::out_t       res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Shared arithmetic unit.
  logic [AW-1:0]         alu_a, alu_b, alu_y;
  logic                  alu_sub;

  // The entry that the last read returned, with never-written slots read as zero.
  logic [15:0]           ent_key;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic                  ent_match, ent_empty, ent_same;
  logic                  scanning;
  logic                  wr_phase;

  logic [IW-1:0]         in_sa_idx, sa_idx, sb_idx;
  logic                  in_swap_ok, in_read_ok;

  assign busy      = (state_r != kstab_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  assign ent_key   = rd_vld_r ? rd_key_r : '0;
  assign ent_cnt   = rd_vld_r ? rd_cnt_r : '0;
  assign ent_same  = (ent_key == req_r.key);
  assign ent_match = ent_same && (ent_cnt != '0);
  assign ent_empty = (ent_key == '0) && (ent_cnt == '0);
  assign scanning  = (state_r == kstab_pkg::S_SCAN) || (state_r == kstab_pkg::S_LAST);
  assign wr_phase  = (state_r == kstab_pkg::S_UPDATE) || (state_r == kstab_pkg::S_SW_WA) ||
                     (state_r == kstab_pkg::S_SW_WB);

  assign in_sa_idx  = IW'(in_data.slot_a);
  assign sa_idx     = IW'(req_r.slot_a);
  assign sb_idx     = IW'(req_r.slot_b);
  assign in_swap_ok = (32'(in_data.slot_a) < SLOTS) && (32'(in_data.slot_b) < SLOTS) &&
                      (in_data.slot_a != in_data.slot_b);
  assign in_read_ok = (32'(in_data.slot_a) < FRONT_WINDOW) && (32'(in_data.slot_a) < SLOTS);

  // Operand selection for the shared adder/subtractor. During a scan it accumulates the
  // key total; in the update cycle it forms the new count or the threshold compare.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (scanning) begin
      alu_a = AW'(acc_r);
      alu_b = AW'(ent_cnt);
    end else if (state_r == kstab_pkg::S_UPDATE) begin
      case (req_r.action)
        kstab_pkg::ACT_ADD: begin
          alu_a = hit_r ? AW'(hit_cnt_r) : '0;
          alu_b = AW'(req_r.amount);
        end
        kstab_pkg::ACT_REMOVE: begin
          alu_a   = AW'(hit_cnt_r);
          alu_b   = AW'(req_r.amount);
          alu_sub = 1'b1;
        end
        kstab_pkg::ACT_QUERY: begin
          alu_a   = AW'(acc_r);
          alu_b   = AW'(req_r.amount);
          alu_sub = 1'b1;
        end
        default: begin
          alu_a = '0;
        end
      endcase
    end
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // Sequencer: next state, memory port control and the result.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    acc_nxt       = acc_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    emp_nxt       = emp_r;
    emp_idx_nxt   = emp_idx_r;
    hold_key_nxt  = hold_key_r;
    hold_cnt_nxt  = hold_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = '0;
    wr_key        = '0;
    wr_cnt        = '0;

    // Scan bookkeeping: first live match, first empty slot and the saturating total.
    if (scanning) begin
      if (ent_match && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = addr_r - IW'(1);
        hit_cnt_nxt = ent_cnt;
      end
      if (ent_empty && !emp_r) begin
        emp_nxt     = 1'b1;
        emp_idx_nxt = addr_r - IW'(1);
      end
      if (ent_same) begin
        acc_nxt = (alu_y > AW'(kstab_pkg::TOTAL_MAX)) ? kstab_pkg::TOTAL_MAX : alu_y[20:0];
      end
    end

    case (state_r)
      kstab_pkg::S_IDLE: begin
        if (start) begin
          req_nxt  = in_data;
          acc_nxt  = '0;
          hit_nxt  = 1'b0;
          emp_nxt  = 1'b0;
          addr_nxt = IW'(1);
          res_nxt  = '0;
          case (in_data.action)
            kstab_pkg::ACT_ADD: begin
              if (in_data.key == '0) begin
                res_nxt.status = kstab_pkg::STAT_BAD_KEY;
                out_valid_nxt  = 1'b1;
              end else if (in_data.amount == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = kstab_pkg::S_SCAN;
              end
            end
            kstab_pkg::ACT_REMOVE: begin
              if (in_data.amount == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = kstab_pkg::S_SCAN;
              end
            end
            kstab_pkg::ACT_QUERY, kstab_pkg::ACT_FIND: begin
              rd_en     = 1'b1;
              state_nxt = kstab_pkg::S_SCAN;
            end
            kstab_pkg::ACT_SWAP: begin
              if (in_swap_ok) begin
                rd_en     = 1'b1;
                rd_addr   = in_sa_idx;
                state_nxt = kstab_pkg::S_SW_B;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            kstab_pkg::ACT_READ: begin
              if (in_read_ok) begin
                rd_en     = 1'b1;
                rd_addr   = in_sa_idx;
                state_nxt = kstab_pkg::S_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      kstab_pkg::S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = addr_r;
        if (addr_r == IW'(SLOTS - 1)) begin
          state_nxt = kstab_pkg::S_LAST;
        end
        addr_nxt = addr_r + IW'(1);
      end

      kstab_pkg::S_LAST: begin
        state_nxt = kstab_pkg::S_UPDATE;
      end

      kstab_pkg::S_UPDATE: begin
        res_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = kstab_pkg::S_IDLE;
        case (req_r.action)
          kstab_pkg::ACT_ADD: begin
            if (!hit_r && !emp_r) begin
              res_nxt.status = kstab_pkg::STAT_FULL;
            end else begin
              res_nxt.found_slot = 5'(hit_r ? hit_idx_r : emp_idx_r);
              if (alu_y[AW-1:COUNT_BITS] != '0) begin
                res_nxt.status = kstab_pkg::STAT_OVERFLOW;
              end else begin
                we      = 1'b1;
                wr_addr = hit_r ? hit_idx_r : emp_idx_r;
                wr_key  = req_r.key;
                wr_cnt  = alu_y[COUNT_BITS-1:0];
              end
            end
          end
          kstab_pkg::ACT_REMOVE: begin
            if (!hit_r) begin
              res_nxt.status = kstab_pkg::STAT_MISSING;
            end else begin
              res_nxt.found_slot = 5'(hit_idx_r);
              if (alu_y[AW-1]) begin
                res_nxt.status = kstab_pkg::STAT_MISSING;
              end else begin
                we      = 1'b1;
                wr_addr = hit_idx_r;
                wr_cnt  = alu_y[COUNT_BITS-1:0];
                wr_key  = (alu_y[COUNT_BITS-1:0] == '0) ? '0 : req_r.key;
              end
            end
          end
          kstab_pkg::ACT_QUERY: begin
            res_nxt.key_total = acc_r;
            res_nxt.enough    = !alu_y[AW-1];
            res_nxt.status    = alu_y[AW-1] ? kstab_pkg::STAT_MISSING : kstab_pkg::STAT_OK;
          end
          kstab_pkg::ACT_FIND: begin
            if (hit_r) begin
              res_nxt.found_slot = 5'(hit_idx_r);
            end else begin
              res_nxt.status = kstab_pkg::STAT_MISSING;
            end
          end
          default: begin
            res_nxt.status = kstab_pkg::STAT_OK;
          end
        endcase
      end

      kstab_pkg::S_SW_B: begin
        rd_en        = 1'b1;
        rd_addr      = sb_idx;
        hold_key_nxt = ent_key;
        hold_cnt_nxt = ent_cnt;
        state_nxt    = kstab_pkg::S_SW_WA;
      end

      kstab_pkg::S_SW_WA: begin
        we        = 1'b1;
        wr_addr   = sa_idx;
        wr_key    = ent_key;
        wr_cnt    = ent_cnt;
        state_nxt = kstab_pkg::S_SW_WB;
      end

      kstab_pkg::S_SW_WB: begin
        we            = 1'b1;
        wr_addr       = sb_idx;
        wr_key        = hold_key_r;
        wr_cnt        = hold_cnt_r;
        res_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = kstab_pkg::S_IDLE;
      end

      kstab_pkg::S_RD: begin
        res_nxt             = '0;
        res_nxt.slot_key    = ent_key;
        res_nxt.slot_amount = 16'(ent_cnt);
        out_valid_nxt       = 1'b1;
        state_nxt           = kstab_pkg::S_IDLE;
      end

      default: begin
        state_nxt = kstab_pkg::S_IDLE;
      end
    endcase
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kstab_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    acc_r      <= acc_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    emp_r      <= emp_nxt;
    emp_idx_r  <= emp_idx_nxt;
    hold_key_r <= hold_key_nxt;
    hold_cnt_r <= hold_cnt_nxt;
    res_r      <= res_nxt;
  end

  // A result strobe always coincides with the block being free again.
  `ASSERT_IMPLIES(a_strobe_idle, out_valid, !busy)
  // Every transfer either keeps the block working or returns its result next cycle.
  `ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid)
  // The table changes only in the update state or in the two swap write states.
  `ASSERT_IMPLIES(a_write_phase, we, wr_phase)
  // A scan never addresses a slot past the end of the table.
  `ASSERT_IMPLIES(a_scan_range, state_r == kstab_pkg::S_SCAN, 32'(addr_r) < SLOTS)

endmodule

// ----- bench/slot_table_checker.sv -----
module slot_table_checker #(
  parameter int SLOTS        = 32,
  parameter int FRONT_WINDOW = 8,
  parameter int COUNT_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  kstab_pkg::in_t  in_data,
  input  logic            out_valid,
  input  kstab_pkg::out_t out_data,
  output int              mismatches,
  output int              awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  logic [15:0]           key_tab [SLOTS];
  logic [COUNT_BITS-1:0] cnt_tab [SLOTS];
  kstab_pkg::out_t       expected_results[$];
  kstab_pkg::out_t       oldest;
  int                    mismatch_count;

  assign mismatches = mismatch_count;
  assign awaited    = expected_results.size();

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  // A slot holds a key only while its count is nonzero.
  function automatic int first_holder(input logic [15:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (key_tab[i] == key && cnt_tab[i] != '0) return i;
    end
    return -1;
  endfunction

  function automatic int first_empty();
    for (int i = 0; i < SLOTS; i++) begin
      if (key_tab[i] == '0 && cnt_tab[i] == '0) return i;
    end
    return -1;
  endfunction

  // Applies one action to the shadow table and returns the result it causes.
  function automatic kstab_pkg::out_t table_apply(input kstab_pkg::in_t it);
    kstab_pkg::out_t       r;
    int                    hit;
    longint                merged;
    longint                sum;
    logic [15:0]           tk;
    logic [COUNT_BITS-1:0] tc;
    r = '0;
    case (it.action)
      kstab_pkg::ACT_ADD: begin
        if (it.key == '0) begin
          r.status = kstab_pkg::STAT_BAD_KEY;
        end else if (it.amount != '0) begin
          hit = first_holder(it.key);
          if (hit >= 0) begin
            r.found_slot = 5'(hit);
            merged = longint'(cnt_tab[hit]) + longint'(it.amount);
            if (merged > CNT_MAX) r.status = kstab_pkg::STAT_OVERFLOW;
            else cnt_tab[hit] = COUNT_BITS'(merged);
          end else begin
            hit = first_empty();
            if (hit < 0) begin
              r.status = kstab_pkg::STAT_FULL;
            end else begin
              r.found_slot = 5'(hit);
              if (longint'(it.amount) > CNT_MAX) begin
                r.status = kstab_pkg::STAT_OVERFLOW;
              end else begin
                key_tab[hit] = it.key;
                cnt_tab[hit] = COUNT_BITS'(it.amount);
              end
            end
          end
        end
      end
      kstab_pkg::ACT_REMOVE: begin
        if (it.amount != '0) begin
          hit = first_holder(it.key);
          if (hit < 0) begin
            r.status = kstab_pkg::STAT_MISSING;
          end else begin
            r.found_slot = 5'(hit);
            if (longint'(cnt_tab[hit]) < longint'(it.amount)) begin
              r.status = kstab_pkg::STAT_MISSING;
            end else begin
              cnt_tab[hit] = cnt_tab[hit] - COUNT_BITS'(it.amount);
              if (cnt_tab[hit] == '0) key_tab[hit] = '0;
            end
          end
        end
      end
      kstab_pkg::ACT_QUERY: begin
        sum = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (key_tab[i] == it.key) sum += longint'(cnt_tab[i]);
        end
        r.enough    = (sum >= longint'(it.amount));
        r.key_total = (sum > longint'(kstab_pkg::TOTAL_MAX)) ? kstab_pkg::TOTAL_MAX
                                                             : sum[20:0];
        r.status    = r.enough ? kstab_pkg::STAT_OK : kstab_pkg::STAT_MISSING;
      end
      kstab_pkg::ACT_SWAP: begin
        if (it.slot_a < SLOTS && it.slot_b < SLOTS && it.slot_a != it.slot_b) begin
          tk = key_tab[it.slot_a];
          tc = cnt_tab[it.slot_a];
          key_tab[it.slot_a] = key_tab[it.slot_b];
          cnt_tab[it.slot_a] = cnt_tab[it.slot_b];
          key_tab[it.slot_b] = tk;
          cnt_tab[it.slot_b] = tc;
        end
      end
      kstab_pkg::ACT_READ: begin
        if (it.slot_a < FRONT_WINDOW && it.slot_a < SLOTS) begin
          r.slot_key    = key_tab[it.slot_a];
          r.slot_amount = 16'(cnt_tab[it.slot_a]);
        end
      end
      kstab_pkg::ACT_FIND: begin
        hit = first_holder(it.key);
        if (hit < 0) r.status = kstab_pkg::STAT_MISSING;
        else r.found_slot = 5'(hit);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial mismatch_count = 0;

  // Results are popped before the new transfer is predicted, so a result and
  // a transfer on the same edge are handled in the right order.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        key_tab[i] = '0;
        cnt_tab[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobed with no transfer awaiting one");
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", 32'(out_data.status), 32'(oldest.status));
          check_field("found_slot", 32'(out_data.found_slot), 32'(oldest.found_slot));
          check_field("key_total", 32'(out_data.key_total), 32'(oldest.key_total));
          check_field("enough", 32'(out_data.enough), 32'(oldest.enough));
          check_field("slot_key", 32'(out_data.slot_key), 32'(oldest.slot_key));
          check_field("slot_amount", 32'(out_data.slot_amount), 32'(oldest.slot_amount));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_results.push_back(table_apply(in_data));
      end
    end
  end

endmodule

// ----- bench/tb_keyed_slot_count_table.sv -----
module tb_keyed_slot_count_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 32;
  localparam int FRONT_WINDOW = 8;
  localparam int COUNT_BITS   = 16;

  // The block decodes only six actions; these two codes must yield an
  // all-zero result and leave the table alone.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int KEY_POOL    = 40;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_LEN   = 150;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  kstab_pkg::in_t  in_data;
  logic            out_valid;
  kstab_pkg::out_t out_data;
  int              mismatches;
  int              awaited;

  // Keys drawn by the random part. Forty keys against 32 slots means the
  // table fills up, keys collide on merges, and lookups mostly hit.
  logic [15:0] key_pool [KEY_POOL];
  bit          idling_on;

  keyed_slot_count_table #(
    .SLOTS        (SLOTS),
    .FRONT_WINDOW (FRONT_WINDOW),
    .COUNT_BITS   (COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  slot_table_checker #(
    .SLOTS        (SLOTS),
    .FRONT_WINDOW (FRONT_WINDOW),
    .COUNT_BITS   (COUNT_BITS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop. The slowest correct run is roughly 1700 items, each a scan plus the
  // longest idle gap, well under 2 ms.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic kstab_pkg::in_t make_cmd(input logic [2:0] action,
                                              input logic [15:0] key,
                                              input logic [15:0] amount,
                                              input logic [4:0] sa,
                                              input logic [4:0] sb);
    kstab_pkg::in_t c;
    c.action = action;
    c.key    = key;
    c.amount = amount;
    c.slot_a = sa;
    c.slot_b = sb;
    return c;
  endfunction

  // Presents one command on the falling edge and holds it until a transfer
  // happens. Each call starts and ends on a falling edge, so start is only
  // assigned once per time step even when commands run back to back.
  task automatic issue(input kstab_pkg::in_t cmd);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 34) begin
      // Mostly short gaps, now and then long ones that land in mid-scan or
      // right after a result.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    if (r < 92) return 16'($urandom());
    if (r < 96) return '0;
    return 16'hFFFF;
  endfunction

  // Small amounts let removes drain slots exactly; big ones push merges
  // toward the count ceiling.
  function automatic logic [15:0] pick_amount(input bit draining);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 75) return draining ? 16'($urandom_range(1, 6)) : 16'($urandom_range(1, 16));
    if (r < 90) return 16'($urandom());
    return 16'($urandom_range(16'hFF00, 16'hFFFF));
  endfunction

  // Fill phases favor adds so the table saturates; drain phases favor
  // removes so slots free up and new keys land in holes mid-table.
  function automatic kstab_pkg::in_t random_cmd(input bit draining);
    kstab_pkg::in_t c;
    int             r;
    int             add_share;
    int             rem_share;
    add_share = draining ? 15 : 55;
    rem_share = draining ? 50 : 10;
    r = $urandom_range(0, 99);
    if (r < add_share) c.action = kstab_pkg::ACT_ADD;
    else if (r < add_share + rem_share) c.action = kstab_pkg::ACT_REMOVE;
    else if (r < add_share + rem_share + 10) c.action = kstab_pkg::ACT_QUERY;
    else if (r < add_share + rem_share + 17) c.action = kstab_pkg::ACT_FIND;
    else if (r < add_share + rem_share + 23) c.action = kstab_pkg::ACT_SWAP;
    else if (r < 98) c.action = kstab_pkg::ACT_READ;
    else c.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
    c.key    = pick_key();
    c.amount = pick_amount(draining);
    c.slot_a = ($urandom_range(0, 99) < 60) ? 5'($urandom_range(0, 7))
                                            : 5'($urandom_range(0, 31));
    c.slot_b = ($urandom_range(0, 9) == 0) ? c.slot_a : 5'($urandom_range(0, 31));
    return c;
  endfunction

  initial begin
    // Every input is known from time zero; reset is released on a falling edge.
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    idling_on = 1'b1;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = 16'(1 + i * 1637);
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: rejections and no-ops first, then the count ceiling
    // with the all-ones key, misses, short removes, swaps and reads on both
    // sides of the front window, and the undecoded action codes.
    issue(make_cmd(kstab_pkg::ACT_ADD,    16'h0000, 16'd5,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_ADD,    16'h0001, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_ADD,    16'hFFFF, 16'hFFFF, 5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_ADD,    16'hFFFF, 16'd1,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_ADD,    16'h0001, 16'd10,   5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_QUERY,  16'hFFFF, 16'hFFFF, 5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_QUERY,  16'h0001, 16'd11,   5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_QUERY,  16'h0000, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_FIND,   16'h0001, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_FIND,   16'h0000, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_FIND,   16'h0002, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_REMOVE, 16'h0001, 16'd11,   5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_REMOVE, 16'h0002, 16'd1,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_REMOVE, 16'h0001, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_SWAP,   16'h0000, 16'd0,    5'd0,  5'd1));
    issue(make_cmd(kstab_pkg::ACT_SWAP,   16'h0000, 16'd0,    5'd3,  5'd3));
    issue(make_cmd(kstab_pkg::ACT_READ,   16'h0000, 16'd0,    5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_READ,   16'h0000, 16'd0,    5'd1,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_READ,   16'h0000, 16'd0,    5'd7,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_READ,   16'h0000, 16'd0,    5'd8,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_READ,   16'h0000, 16'd0,    5'd31, 5'd0));
    issue(make_cmd(kstab_pkg::ACT_REMOVE, 16'h0001, 16'd10,   5'd0,  5'd0));
    issue(make_cmd(kstab_pkg::ACT_SWAP,   16'h0000, 16'd0,    5'd31, 5'd30));
    issue(make_cmd(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 5'd31, 5'd31));
    issue(make_cmd(ACT_SPARE_HI, 16'hFFFF, 16'hFFFF, 5'd31, 5'd31));

    // Random part, alternating fill and drain phases. A stretch in the
    // middle runs with no idle cycles so transfers follow busy dropping
    // immediately.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling_on = !(n >= 700 && n < 1000);
      issue(random_cmd(((n / PHASE_LEN) % 2) == 1));
    end
    start <= 1'b0;

    // Drain the outstanding results, then leave a full scan's worth of
    // cycles for anything unexpected to show up.
    wait (awaited == 0);
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
